>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mbsrm_pkg.sv
package mbsrm_pkg;

   localparam int HOLDING_COUNT_DEF  = 16;
   localparam int INPUT_COUNT_DEF    = 16;
   localparam int COIL_COUNT_DEF     = 16;
   localparam int DISCRETE_COUNT_DEF = 16;
   localparam int FRAME_BYTES_DEF    = 256;

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 16;

   localparam logic [CSR_IW-1:0] CSR_SLAVE_ADDR    = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_HOLDING_BASE  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_INPUT_BASE    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_COIL_BASE     = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_DISCRETE_BASE = 3'd4;

   localparam logic [1:0] KIND_BYTE      = 2'd0;
   localparam logic [1:0] KIND_LOAD_REG  = 2'd1;
   localparam logic [1:0] KIND_LOAD_BITS = 2'd2;

   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

   localparam logic [7:0] EXC_FUNCTION = 8'd1;
   localparam logic [7:0] EXC_ADDRESS  = 8'd2;
   localparam logic [7:0] EXC_COUNT    = 8'd3;
   localparam logic [7:0] EXC_FLAG     = 8'h80;

   localparam logic [15:0] MAX_READ_REGS  = 16'd125;
   localparam logic [15:0] MAX_WRITE_REGS = 16'd123;
   localparam logic [15:0] COIL_ON        = 16'hFF00;
   localparam logic [15:0] COIL_OFF       = 16'h0000;
   localparam int          DATA_START     = 7;

   typedef enum logic [2:0] {ST_IDLE, ST_EVAL, ST_READ, ST_APPLY, ST_EMIT} state_type;
   typedef enum logic [2:0] {RSP_NONE, RSP_EXC, RSP_ECHO, RSP_BITS, RSP_REGS} rsp_kind_type;
   typedef enum logic [2:0] {WR_NONE, WR_COIL, WR_REG, WR_COILS, WR_REGS} wr_op_type;

   typedef struct packed {
      logic take;
      logic eval;
      logic read;
      logic apply;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic read_done;
      logic emit_done;
   } status_type;

endpackage

>>> rtl/core/mbsrm_ctrl.sv
module mbsrm_ctrl
   import mbsrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.close) state_in = ST_EVAL;
         end
         ST_EVAL:  state_in = ST_READ;
         ST_READ: begin
            if (status.read_done) state_in = ST_APPLY;
         end
         ST_APPLY: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.emit_done) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:  cmd.take  = 1'b1;
         ST_EVAL:  cmd.eval  = 1'b1;
         ST_READ:  cmd.read  = 1'b1;
         ST_APPLY: cmd.apply = 1'b1;
         ST_EMIT: begin
            cmd.emit   = 1'b1;
            cmd.finish = status.emit_done;
         end
         default:  cmd = '0;
      endcase
   end

endmodule

>>> rtl/core/mbsrm_dp.sv
module mbsrm_dp
   import mbsrm_pkg::*;
#(
   parameter int HOLDING_COUNT  = HOLDING_COUNT_DEF,
   parameter int INPUT_COUNT    = INPUT_COUNT_DEF,
   parameter int COIL_COUNT     = COIL_COUNT_DEF,
   parameter int DISCRETE_COUNT = DISCRETE_COUNT_DEF,
   parameter int FRAME_BYTES    = FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data,
   input  logic              req_tvalid,
   input  logic [31:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   localparam int FAW = $clog2(FRAME_BYTES);
   localparam int LW  = FAW + 1;
   localparam int HIW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
   localparam int IIW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

   logic [7:0]  rx_byte;
   logic [4:0]  reg_index;
   logic [15:0] load_value;
   logic        accept;

   assign rx_byte    = req_tdata[7:0];
   assign reg_index  = req_tdata[12:8];
   assign load_value = req_tdata[28:13];
   assign accept     = req_tvalid && cmd.take;

   logic [7:0]  slave_addr_ff;
   logic [15:0] holding_base_ff, input_base_ff, coil_base_ff, discrete_base_ff;

   logic [7:0]  frame_mem [FRAME_BYTES];
   logic [7:0]  mem_q_ff;
   logic [LW-1:0] len_ff;
   logic [7:0]  hdr_ff [6];
   logic [7:0]  rxb [6];

   logic [15:0] holding_ff [HOLDING_COUNT];
   logic [15:0] input_ff [INPUT_COUNT];
   logic [COIL_COUNT-1:0]     coil_ff;
   logic [DISCRETE_COUNT-1:0] discrete_ff;

   rsp_kind_type rsp_kind_ff, ev_kind;
   wr_op_type    wr_op_ff, ev_wr;
   logic [7:0]   exc_code_ff, ev_code, fc_ff;
   logic [6:0]   tx_len_ff, ev_len, rd_cnt_ff, ev_cnt, k_ff, ptr_ff;
   logic [4:0]   off_ff;
   logic [5:0]   n_ff;
   logic [15:0]  val_ff;

   // ---- config
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff    <= 8'd1;
         holding_base_ff  <= '0;
         input_base_ff    <= '0;
         coil_base_ff     <= '0;
         discrete_base_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLAVE_ADDR:    slave_addr_ff    <= csr_data[7:0];
            CSR_HOLDING_BASE:  holding_base_ff  <= csr_data;
            CSR_INPUT_BASE:    input_base_ff    <= csr_data;
            CSR_COIL_BASE:     coil_base_ff     <= csr_data;
            CSR_DISCRETE_BASE: discrete_base_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- frame capture
   logic take_byte, store_byte;
   assign take_byte  = accept && (req_tuser == KIND_BYTE);
   assign store_byte = take_byte && (len_ff < LW'(FRAME_BYTES));
   assign status.close = take_byte && req_tlast;

   always_ff @(posedge clock) begin
      if (store_byte) frame_mem[len_ff[FAW-1:0]] <= rx_byte;
   end

   always_ff @(posedge clock) begin
      if (store_byte && (len_ff < LW'(6))) hdr_ff[len_ff[2:0]] <= rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         len_ff <= '0;
      end else if (store_byte) begin
         len_ff <= len_ff + LW'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         rxb[i] = (len_ff > LW'(i)) ? hdr_ff[i] : 8'h00;
      end
   end

   // ---- request decode
   logic [7:0]  fc;
   logic [15:0] start, n, base, lim, off_w;
   logic [16:0] size, n_eff;
   logic        known, cnt_chk, count_bad, range_ok;
   rsp_kind_type ok_kind;
   wr_op_type    ok_wr;

   always_comb begin
      fc      = rxb[1];
      start   = {rxb[2], rxb[3]};
      n       = {rxb[4], rxb[5]};
      known   = 1'b1;
      cnt_chk = 1'b1;
      n_eff   = {1'b0, n};
      base    = holding_base_ff;
      size    = 17'(HOLDING_COUNT);
      lim     = MAX_READ_REGS;
      ok_kind = RSP_ECHO;
      ok_wr   = WR_NONE;
      unique case (fc)
         FC_READ_COILS: begin
            base = coil_base_ff; size = 17'(COIL_COUNT); lim = 16'(COIL_COUNT);
            ok_kind = RSP_BITS;
         end
         FC_READ_DISCRETE: begin
            base = discrete_base_ff; size = 17'(DISCRETE_COUNT);
            lim = 16'(DISCRETE_COUNT); ok_kind = RSP_BITS;
         end
         FC_READ_HOLDING: ok_kind = RSP_REGS;
         FC_READ_INPUT: begin
            base = input_base_ff; size = 17'(INPUT_COUNT); ok_kind = RSP_REGS;
         end
         FC_WRITE_COIL: begin
            base = coil_base_ff; size = 17'(COIL_COUNT); cnt_chk = 1'b0;
            n_eff = 17'd1; ok_wr = WR_COIL;
         end
         FC_WRITE_REG: begin
            cnt_chk = 1'b0; n_eff = 17'd1; ok_wr = WR_REG;
         end
         FC_WRITE_COILS: begin
            base = coil_base_ff; size = 17'(COIL_COUNT); lim = 16'(COIL_COUNT);
            ok_wr = WR_COILS;
         end
         FC_WRITE_REGS: begin
            lim = MAX_WRITE_REGS; ok_wr = WR_REGS;
         end
         default: known = 1'b0;
      endcase
      count_bad = cnt_chk && ((n == 16'd0) || (n > lim));
      range_ok  = (start >= base) && (({1'b0, start} + n_eff) <= ({1'b0, base} + size));
      off_w     = start - base;
   end

   always_comb begin
      ev_kind = RSP_EXC;
      ev_wr   = WR_NONE;
      ev_code = EXC_FUNCTION;
      ev_len  = 7'd3;
      ev_cnt  = '0;
      if (rxb[0] != slave_addr_ff) begin
         ev_kind = RSP_NONE;
         ev_len  = '0;
      end else if (!known) begin
         ev_code = EXC_FUNCTION;
      end else if (count_bad) begin
         ev_code = EXC_COUNT;
      end else if (!range_ok) begin
         ev_code = EXC_ADDRESS;
      end else begin
         ev_kind = ok_kind;
         ev_wr   = ok_wr;
         case (ok_kind)
            RSP_BITS: ev_len = (n[5:0] > 6'd8) ? 7'd5 : 7'd4;
            RSP_REGS: ev_len = 7'd3 + {n[5:0], 1'b0};
            default:  ev_len = 7'd6;
         endcase
         case (ok_wr)
            WR_COILS: ev_cnt = 7'd2;
            WR_REGS:  ev_cnt = {n[5:0], 1'b0};
            default:  ev_cnt = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_kind_ff <= RSP_NONE;
         wr_op_ff    <= WR_NONE;
         tx_len_ff   <= '0;
         rd_cnt_ff   <= '0;
      end else if (cmd.eval) begin
         rsp_kind_ff <= ev_kind;
         wr_op_ff    <= ev_wr;
         tx_len_ff   <= ev_len;
         rd_cnt_ff   <= ev_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         exc_code_ff <= ev_code;
         fc_ff       <= fc;
         off_ff      <= off_w[4:0];
         n_ff        <= n[5:0];
         val_ff      <= n;
      end
   end

   // ---- data bytes of multiple writes
   logic [8:0] rd_addr;
   logic       issue, pend_ff, inr_ff;
   logic [6:0] j_ff;
   logic [7:0] rd_byte, hi_ff;
   logic [15:0] acc_ff;

   assign rd_addr = 9'(DATA_START) + 9'(ptr_ff);
   assign issue   = cmd.read && (ptr_ff < rd_cnt_ff);
   assign rd_byte = inr_ff ? mem_q_ff : 8'h00;
   assign status.read_done = !pend_ff && (ptr_ff == rd_cnt_ff);

   always_ff @(posedge clock) begin
      mem_q_ff <= frame_mem[rd_addr[FAW-1:0]];
      j_ff     <= ptr_ff;
      inr_ff   <= rd_addr < 9'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.eval) begin
         ptr_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (issue) ptr_ff <= ptr_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         if (!j_ff[0]) hi_ff <= rd_byte;
         if (j_ff[0]) acc_ff[15:8] <= rd_byte;
         else acc_ff[7:0] <= rd_byte;
      end
   end

   // ---- tables
   logic [5:0]  wr_idx;
   logic [31:0] cmask, cnew;

   assign wr_idx = 6'(off_ff) + j_ff[6:1];
   assign cmask  = ((32'd1 << n_ff) - 32'd1) << off_ff;
   assign cnew   = (32'(coil_ff) & ~cmask) | ((32'(acc_ff) << off_ff) & cmask);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOLDING_COUNT; i++) holding_ff[i] <= '0;
      end else if (pend_ff && j_ff[0] && (wr_op_ff == WR_REGS)) begin
         holding_ff[wr_idx[HIW-1:0]] <= {hi_ff, rd_byte};
      end else if (cmd.apply && (wr_op_ff == WR_REG)) begin
         holding_ff[off_ff[HIW-1:0]] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < INPUT_COUNT; i++) input_ff[i] <= '0;
      end else if (accept && (req_tuser == KIND_LOAD_REG) && (reg_index < 5'(INPUT_COUNT)))
      begin
         input_ff[reg_index[IIW-1:0]] <= load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discrete_ff <= '0;
      end else if (accept && (req_tuser == KIND_LOAD_BITS)) begin
         discrete_ff <= load_value[DISCRETE_COUNT-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_ff <= '0;
      end else if (cmd.apply) begin
         if (wr_op_ff == WR_COILS) begin
            coil_ff <= cnew[COIL_COUNT-1:0];
         end else if (wr_op_ff == WR_COIL) begin
            if (val_ff == COIL_ON) coil_ff <= coil_ff | COIL_COUNT'(32'd1 << off_ff);
            else if (val_ff == COIL_OFF) coil_ff <= coil_ff & ~COIL_COUNT'(32'd1 << off_ff);
         end
      end
   end

   // ---- response bytes
   logic [6:0]  idx;
   logic [5:0]  rd_idx;
   logic [15:0] reg_word, bits16, bmask, bval;
   logic [7:0]  out_byte;
   logic        load, ov_ff;

   assign idx    = k_ff - 7'd3;
   assign rd_idx = 6'(off_ff) + idx[6:1];
   assign bits16 = (fc_ff == FC_READ_COILS) ? 16'(coil_ff) : 16'(discrete_ff);
   assign bmask  = 16'((17'd1 << n_ff) - 17'd1);
   assign bval   = (bits16 >> off_ff) & bmask;
   assign reg_word = (fc_ff == FC_READ_HOLDING) ? holding_ff[rd_idx[HIW-1:0]]
                                                : input_ff[rd_idx[IIW-1:0]];

   always_comb begin
      out_byte = 8'h00;
      case (rsp_kind_ff)
         RSP_EXC:  out_byte = (k_ff == 7'd1) ? (fc_ff | EXC_FLAG) : exc_code_ff;
         RSP_ECHO: out_byte = (k_ff < 7'd6) ? rxb[k_ff[2:0]] : 8'h00;
         RSP_BITS: begin
            if (k_ff == 7'd1) out_byte = fc_ff;
            else if (k_ff == 7'd2) out_byte = 8'(tx_len_ff - 7'd3);
            else if (k_ff == 7'd3) out_byte = bval[7:0];
            else out_byte = bval[15:8];
         end
         RSP_REGS: begin
            if (k_ff == 7'd1) out_byte = fc_ff;
            else if (k_ff == 7'd2) out_byte = {1'b0, n_ff, 1'b0};
            else out_byte = idx[0] ? reg_word[7:0] : reg_word[15:8];
         end
         default:  out_byte = 8'h00;
      endcase
      if (k_ff == 7'd0) out_byte = slave_addr_ff;
   end

   assign load = cmd.emit && (k_ff < tx_len_ff) && (!ov_ff || rsp_tready);
   assign status.emit_done = (k_ff == tx_len_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.eval) begin
         k_ff <= '0;
      end else if (load) begin
         k_ff <= k_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (load) begin
         ov_ff <= 1'b1;
      end else if (rsp_tready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata <= out_byte;
         rsp_tlast <= (k_ff == tx_len_ff - 7'd1);
         rsp_tuser <= (rsp_kind_ff == RSP_EXC);
      end
   end

   assign rsp_tvalid = ov_ff;

`include "assert_macros.svh"

   `ASSERT_HOLDS(a_emit_bound, clock, reset, k_ff <= tx_len_ff, "byte count past response length")
   `ASSERT_HOLDS(a_read_bound, clock, reset, ptr_ff <= rd_cnt_ff, "frame read past data length")
   `ASSERT_NEXT(a_len_clear, clock, reset, cmd.finish, len_ff == '0, "frame not cleared at end")

endmodule

>>> rtl/core/modbus_slave_register_map.sv
// Request words and table loads: one word per cycle while the frame engine is idle.
// Frame end: req_tready stays low through evaluation, the data byte reads of functions
// 15 and 16 (one frame memory read a cycle), the table update and the response.
// A low rsp_tready stalls the response phase.
// Reset is synchronous, active high: clears tables, config and control; the
// frame memory is not cleared.
module modbus_slave_register_map
   import mbsrm_pkg::*;
#(
   parameter int HOLDING_COUNT  = HOLDING_COUNT_DEF,
   parameter int INPUT_COUNT    = INPUT_COUNT_DEF,
   parameter int COIL_COUNT     = COIL_COUNT_DEF,
   parameter int DISCRETE_COUNT = DISCRETE_COUNT_DEF,
   parameter int FRAME_BYTES    = FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,  // rx_byte, reg_index, load_value
   input  logic [1:0]        req_tuser,  // kind
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,  // tx_byte
   output logic              rsp_tuser,  // is_exception
   output logic              rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   assign req_tready = cmd.take;

   mbsrm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mbsrm_dp #(
      .HOLDING_COUNT  (HOLDING_COUNT),
      .INPUT_COUNT    (INPUT_COUNT),
      .COIL_COUNT     (COIL_COUNT),
      .DISCRETE_COUNT (DISCRETE_COUNT),
      .FRAME_BYTES    (FRAME_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> verif/tb.sv
module tb;
   import mbsrm_pkg::*;

   localparam int LIMIT = 1500000;
   localparam int DRAIN = 400;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  rx;
      logic        eof;
      logic [4:0]  idx;
      logic [15:0] val;
   } req_word_type;

   typedef struct {
      logic [7:0] b;
      logic       last;
      logic       exc;
   } rsp_word_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_we = 0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              req_tlast = 0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [7:0]        rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;

   modbus_slave_register_map DUT (.*);

   initial forever #2 clock = ~clock;

   req_word_type pending[$];
   rsp_word_type resp_q[$];
   req_word_type cur;
   logic      req_fire = 0;
   int        cycles = 0, errors = 0, words_in = 0, bytes_out = 0, frames = 0, excs = 0;
   int        quiet_lo = 3000, quiet_hi = 9000;

   // shadow of the slave
   logic [7:0]  my_addr;
   logic [15:0] hbase, ibase, cbase, dbase;
   logic [7:0]  fstore[256];
   int          flen;
   logic [15:0] hregs[16], iregs[16];
   logic [15:0] coils, dbits;
   rsp_word_type tx[$];
   logic        tx_exc;

   function automatic bit idle_now();
      if (cycles >= quiet_lo && cycles < quiet_hi) return 0;
      return $urandom_range(0, 99) < 6;
   endfunction

   function automatic int rx_at(int i);
      return (i < flen) ? int'(fstore[i]) : 0;
   endfunction

   function automatic int rx_w(int i);
      return (rx_at(i) << 8) | rx_at(i + 1);
   endfunction

   function automatic void put(int b);
      rsp_word_type w;
      w.b = b[7:0]; w.last = 0; w.exc = 0;
      if (tx.size() < 64) tx.push_back(w);
   endfunction

   function automatic void exc_reply(logic [7:0] code);
      tx.delete();
      tx_exc = 1;
      put(my_addr);
      put(rx_at(1) | EXC_FLAG);
      put(code);
   endfunction

   function automatic void echo();
      tx.delete();
      put(my_addr);
      for (int i = 1; i < 6; i++) put(rx_at(i));
   endfunction

   function automatic bit in_range(int s, int n, int base, int size);
      return s >= base && s + n <= base + size;
   endfunction

   function automatic void read_bits(logic [15:0] bits, int base);
      int s, n, nb, v, rem, m;
      s = rx_w(2); n = rx_w(4);
      if (n < 1 || n > 16) begin exc_reply(EXC_COUNT); return; end
      if (!in_range(s, n, base, 16)) begin exc_reply(EXC_ADDRESS); return; end
      v = int'(bits) >> (s - base);
      nb = (n + 7) / 8;
      put(my_addr); put(rx_at(1)); put(nb);
      for (int i = 0; i < nb; i++) begin
         rem = n - i * 8;
         m = (rem >= 8) ? 'hFF : ((1 << rem) - 1);
         put((v >> (i * 8)) & m);
      end
   endfunction

   function automatic void read_regs(bit hold, int base);
      int s, n, off;
      logic [15:0] r;
      s = rx_w(2); n = rx_w(4);
      if (n < 1 || n > int'(MAX_READ_REGS)) begin exc_reply(EXC_COUNT); return; end
      if (!in_range(s, n, base, 16)) begin exc_reply(EXC_ADDRESS); return; end
      off = s - base;
      put(my_addr); put(rx_at(1)); put(n * 2);
      for (int i = 0; i < n; i++) begin
         r = hold ? hregs[off + i] : iregs[off + i];
         put(r[15:8]); put(r[7:0]);
      end
   endfunction

   function automatic void exec_frame();
      int s, n, v, off, b;
      logic [7:0] fcode;
      tx.delete();
      tx_exc = 0;
      if (rx_at(0) != int'(my_addr)) return;
      s = rx_w(2); n = rx_w(4);
      fcode = 8'(rx_at(1));
      case (fcode)
         FC_READ_COILS:    read_bits(coils, cbase);
         FC_READ_DISCRETE: read_bits(dbits, dbase);
         FC_READ_HOLDING:  read_regs(1, hbase);
         FC_READ_INPUT:    read_regs(0, ibase);
         FC_WRITE_COIL: begin
            if (!in_range(s, 1, cbase, 16)) exc_reply(EXC_ADDRESS);
            else begin
               if (n == int'(COIL_ON)) coils[s - cbase] = 1;
               else if (n == int'(COIL_OFF)) coils[s - cbase] = 0;
               echo();
            end
         end
         FC_WRITE_REG: begin
            if (!in_range(s, 1, hbase, 16)) exc_reply(EXC_ADDRESS);
            else begin
               hregs[s - hbase] = n[15:0];
               echo();
            end
         end
         FC_WRITE_COILS: begin
            if (n < 1 || n > 16) exc_reply(EXC_COUNT);
            else if (!in_range(s, n, cbase, 16)) exc_reply(EXC_ADDRESS);
            else begin
               off = s - cbase;
               for (int i = 0; i < n; i++) begin
                  b = (rx_at(DATA_START + i / 8) >> (i % 8)) & 1;
                  coils[off + i] = b[0];
               end
               echo();
            end
         end
         FC_WRITE_REGS: begin
            if (n < 1 || n > int'(MAX_WRITE_REGS)) exc_reply(EXC_COUNT);
            else if (!in_range(s, n, hbase, 16)) exc_reply(EXC_ADDRESS);
            else begin
               off = s - hbase;
               for (int i = 0; i < n; i++) begin
                  v = rx_w(DATA_START + 2 * i);
                  hregs[off + i] = v[15:0];
               end
               echo();
            end
         end
         default: exc_reply(EXC_FUNCTION);
      endcase
   endfunction

   function automatic void predict(req_word_type w);
      rsp_word_type r;
      case (w.kind)
         KIND_LOAD_REG:  if (w.idx < 16) iregs[w.idx] = w.val;
         KIND_LOAD_BITS: dbits = w.val;
         KIND_BYTE: begin
            if (flen < 256) begin
               fstore[flen] = w.rx;
               flen++;
            end
            if (w.eof) begin
               exec_frame();
               flen = 0;
               frames++;
               if (tx_exc) excs++;
               for (int k = 0; k < tx.size(); k++) begin
                  r = tx[k];
                  r.last = (k == tx.size() - 1);
                  r.exc = tx_exc;
                  resp_q.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !idle_now();
         if (!req_tvalid || req_fire) begin
            if (pending.size() > 0 && !idle_now()) begin
               cur = pending.pop_front();
               req_tvalid <= 1;
               req_tdata <= {3'b000, cur.val, cur.idx, cur.rx};
               req_tuser <= cur.kind;
               req_tlast <= cur.eof;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout with %0d bytes still expected", resp_q.size());
         $display("tb NOT OK");
         $finish;
      end else if (!reset) begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            words_in++;
            predict('{req_tuser, req_tdata[7:0], req_tlast, req_tdata[12:8],
                      req_tdata[28:13]});
         end
         if (rsp_tvalid && rsp_tready) begin
            bytes_out++;
            if (resp_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected rsp word %h last %b exc %b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               e = resp_q.pop_front();
               if (e.b !== rsp_tdata || e.last !== rsp_tlast || e.exc !== rsp_tuser) begin
                  errors++;
                  if (errors <= 10)
                     $display("rsp mismatch: exp %h/%b/%b got %h/%b/%b", e.b, e.last,
                              e.exc, rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
      end else begin
         req_fire <= 0;
      end
   end

   task automatic send(logic [7:0] fb[$]);
      req_word_type w;
      foreach (fb[i]) begin
         w.kind = KIND_BYTE; w.rx = fb[i]; w.eof = (i == fb.size() - 1);
         w.idx = 5'($urandom); w.val = 16'($urandom);
         pending.push_back(w);
      end
   endtask

   task automatic load(logic [1:0] kind, logic [4:0] idx, logic [15:0] val);
      req_word_type w;
      w.kind = kind; w.rx = 8'($urandom); w.eof = 1'($urandom);
      w.idx = idx; w.val = val;
      pending.push_back(w);
   endtask

   task automatic drain();
      wait (pending.size() == 0 && !req_tvalid && resp_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IW-1:0] idx, logic [15:0] d);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_data <= d;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_SLAVE_ADDR:    my_addr = d[7:0];
         CSR_HOLDING_BASE:  hbase = d;
         CSR_INPUT_BASE:    ibase = d;
         CSR_COIL_BASE:     cbase = d;
         default:           dbase = d;
      endcase
   endtask

   task automatic set_map(logic [7:0] a, logic [15:0] h, logic [15:0] i, logic [15:0] c,
                          logic [15:0] d);
      csr_write(CSR_SLAVE_ADDR, a);
      csr_write(CSR_HOLDING_BASE, h);
      csr_write(CSR_INPUT_BASE, i);
      csr_write(CSR_COIL_BASE, c);
      csr_write(CSR_DISCRETE_BASE, d);
   endtask

   task automatic hdr(ref logic [7:0] fb[$], input logic [7:0] a, input logic [7:0] fc,
                      input logic [15:0] s, input logic [15:0] n);
      fb = {a, fc, s[15:8], s[7:0], n[15:8], n[7:0]};
   endtask

   task automatic rand_frame();
      logic [7:0]  fb[$];
      logic [7:0]  fc, a;
      logic [15:0] base, s, n;
      int          r, nd;
      r = $urandom_range(0, 19);
      a = (r == 18) ? 8'($urandom) : my_addr;
      case (r % 8)
         0: fc = FC_READ_COILS;
         1: fc = FC_READ_DISCRETE;
         2: fc = FC_READ_HOLDING;
         3: fc = FC_READ_INPUT;
         4: fc = FC_WRITE_COIL;
         5: fc = FC_WRITE_REG;
         6: fc = FC_WRITE_COILS;
         default: fc = FC_WRITE_REGS;
      endcase
      if (r == 16 || r == 17) fc = 8'($urandom);
      case (fc)
         FC_READ_COILS, FC_WRITE_COIL, FC_WRITE_COILS: base = cbase;
         FC_READ_DISCRETE: base = dbase;
         FC_READ_INPUT: base = ibase;
         default: base = hbase;
      endcase
      s = base + 16'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) s = base - 16'($urandom_range(1, 3));
      else if ($urandom_range(0, 9) == 0) s = base + 16'($urandom_range(16, 18));
      n = 16'($urandom_range(1, 17 - (s - base) % 17));
      if ($urandom_range(0, 9) == 0) n = 16'($urandom_range(0, 18));
      else if ($urandom_range(0, 19) == 0) n = ($urandom_range(0, 1)) ? MAX_READ_REGS + 16'd1
                                                                     : MAX_WRITE_REGS + 16'd1;
      else if ($urandom_range(0, 29) == 0) n = 16'($urandom);
      if (fc == FC_WRITE_COIL)
         case ($urandom_range(0, 3))
            0, 1: n = COIL_ON;
            2: n = COIL_OFF;
            default: n = 16'($urandom);
         endcase
      if (fc == FC_WRITE_REG) n = 16'($urandom);
      hdr(fb, a, fc, s, n);
      nd = 0;
      if (fc == FC_WRITE_COILS) nd = (n <= 16) ? (n + 7) / 8 : 2;
      if (fc == FC_WRITE_REGS) nd = (n <= 16) ? 2 * n : 4;
      if (nd > 0) fb.push_back(8'(nd));
      repeat (nd) fb.push_back(8'($urandom));
      if (r == 19) fb = fb[0:$urandom_range(0, fb.size() - 1)];
      send(fb);
   endtask

   task automatic run_phase(int words);
      int goal;
      goal = pending.size() + words;
      while (pending.size() < goal)
         case ($urandom_range(0, 9))
            0: load(KIND_LOAD_REG, 5'($urandom), 16'($urandom));
            1: load($urandom_range(0, 1) ? KIND_LOAD_BITS : 2'd3, 5'($urandom),
                    16'($urandom));
            default: rand_frame();
         endcase
      drain();
   endtask

   initial begin
      logic [7:0] fb[$];
      my_addr = 1; hbase = 0; ibase = 0; cbase = 0; dbase = 0; flen = 0;
      coils = 0; dbits = 0;
      foreach (hregs[i]) begin hregs[i] = 0; iregs[i] = 0; end
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 0;

      set_map(8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
      load(KIND_LOAD_REG, 5'd15, 16'hFFFF);
      load(KIND_LOAD_REG, 5'd31, 16'h1234);
      load(KIND_LOAD_BITS, 5'd0, 16'hA5C3);
      load(2'd3, 5'd0, 16'hFFFF);
      hdr(fb, 8'd1, FC_READ_INPUT, 16'd0, 16'd16); send(fb);
      hdr(fb, 8'd1, FC_WRITE_COIL, 16'd15, COIL_ON); send(fb);
      hdr(fb, 8'd1, FC_READ_COILS, 16'd8, 16'd8); send(fb);
      fb = {8'd1, FC_READ_DISCRETE, 8'd0}; send(fb);
      drain();

      // oversized frame: bytes past the store are dropped
      hdr(fb, 8'd1, FC_READ_HOLDING, 16'd0, 16'd2);
      repeat (260) fb.push_back(8'($urandom));
      send(fb);
      run_phase(50);

      set_map(8'd247, 16'hFFF0, 16'hFFF0, 16'hFFF0, 16'hFFF0);
      run_phase(50);
      set_map(8'd1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      run_phase(30);
      set_map(8'($urandom_range(1, 247)), 16'($urandom), 16'($urandom_range(0, 40)),
              16'($urandom), 16'($urandom_range(100, 200)));
      run_phase(50);

      $display("%0d request words, %0d frames (%0d exception replies), %0d reply bytes",
               words_in, frames, excs, bytes_out);
      $display("four register maps incl. address 1/247 and bases 0/high end");
      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mbsrm_pkg.sv
rtl/core/mbsrm_ctrl.sv
rtl/core/mbsrm_dp.sv
rtl/core/modbus_slave_register_map.sv
verif/tb.sv
